// ----- design/utf8s_pkg.sv -----
// shared types, constants and byte classification for the utf-8 text and program sniffer
package utf8s_pkg;

  // examined head of the file, in bytes
  localparam int unsigned WINDOW_BYTES = 64 * 1024;
  // byte counter width, wide enough to hold WINDOW_BYTES itself
  localparam int unsigned CNT_W = $clog2(WINDOW_BYTES + 1);

  // utf-8 lead byte ranges
  localparam logic [7:0] ASCII_END   = 8'h80;
  localparam logic [7:0] LEAD2_LO    = 8'hc2;
  localparam logic [7:0] LEAD2_HI    = 8'hdf;
  localparam logic [7:0] LEAD3_LO    = 8'he0;
  localparam logic [7:0] LEAD3_HI    = 8'hef;
  localparam logic [7:0] LEAD4_LO    = 8'hf0;
  localparam logic [7:0] LEAD4_HI    = 8'hf4;
  localparam logic [7:0] CONT_MASK   = 8'hc0;
  localparam logic [7:0] CONT_BITS   = 8'h80;

  // program magic
  localparam logic [7:0] ELF_MAGIC0  = 8'h7f;
  localparam logic [7:0] ELF_MAGIC1  = 8'h45;
  localparam logic [7:0] ELF_MAGIC2  = 8'h4c;
  localparam logic [7:0] ELF_MAGIC3  = 8'h46;
  localparam logic [7:0] BANG_MAGIC0 = 8'h23;
  localparam logic [7:0] BANG_MAGIC1 = 8'h21;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_file;
  } item_t;

  // one result item
  typedef struct packed {
    logic is_program;
    logic is_text;
  } verdict_t;

  // lead byte decode
  typedef struct packed {
    logic       bad;
    logic [1:0] owed;
  } lead_t;

  // classify a byte seen where a new sequence starts
  function automatic lead_t lead_class(logic [7:0] b);
    lead_t r;
    r.bad  = 1'b0;
    r.owed = 2'd0;
    if (b == 8'h00) begin
      r.bad = 1'b1;
    end else if (b < ASCII_END) begin
      r.owed = 2'd0;
    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      r.owed = 2'd1;
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      r.owed = 2'd2;
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      r.owed = 2'd3;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

  // expected elf magic byte at a head position
  function automatic logic [7:0] elf_byte(logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = ELF_MAGIC0;
      2'd1:    r = ELF_MAGIC1;
      2'd2:    r = ELF_MAGIC2;
      default: r = ELF_MAGIC3;
    endcase
    return r;
  endfunction

  // expected shebang byte at a head position
  function automatic logic [7:0] bang_byte(logic idx);
    return idx ? BANG_MAGIC1 : BANG_MAGIC0;
  endfunction

endpackage

// ----- design/utf8s_core.sv -----
// per-file scan state and verdict logic of the sniffer
module utf8s_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  utf8s_pkg::item_t   item,
  output utf8s_pkg::verdict_t verdict
);

  logic [utf8s_pkg::CNT_W-1:0] bytes_seen, bytes_seen_next;
  logic [1:0]                  continuations_left, continuations_left_next;
  logic                        text_failed, text_failed_next;
  logic                        sequence_bad, sequence_bad_next;
  logic                        elf_prefix_match, elf_prefix_match_next;
  logic                        shebang_prefix_match, shebang_prefix_match_next;
  logic                        take_byte;
  logic                        window_full;
  utf8s_pkg::lead_t            lead;

  assign window_full = bytes_seen_next >= utf8s_pkg::CNT_W'(utf8s_pkg::WINDOW_BYTES);
  assign take_byte   = item.byte_present &&
                       (bytes_seen < utf8s_pkg::CNT_W'(utf8s_pkg::WINDOW_BYTES));
  assign lead        = utf8s_pkg::lead_class(item.data_byte);

  // state after taking this item's byte
  always_comb begin
    bytes_seen_next           = bytes_seen;
    continuations_left_next   = continuations_left;
    text_failed_next          = text_failed;
    sequence_bad_next         = sequence_bad;
    elf_prefix_match_next     = elf_prefix_match;
    shebang_prefix_match_next = shebang_prefix_match;
    if (take_byte) begin
      if (bytes_seen < utf8s_pkg::CNT_W'(4) &&
          item.data_byte != utf8s_pkg::elf_byte(bytes_seen[1:0])) begin
        elf_prefix_match_next = 1'b0;
      end
      if (bytes_seen < utf8s_pkg::CNT_W'(2) &&
          item.data_byte != utf8s_pkg::bang_byte(bytes_seen[0])) begin
        shebang_prefix_match_next = 1'b0;
      end
      if (continuations_left != 2'd0) begin
        // continuation byte of an open sequence
        if ((item.data_byte & utf8s_pkg::CONT_MASK) != utf8s_pkg::CONT_BITS) begin
          sequence_bad_next = 1'b1;
        end
        continuations_left_next = continuations_left - 2'd1;
        if (continuations_left_next == 2'd0) begin
          if (sequence_bad_next) begin
            text_failed_next = 1'b1;
          end
          sequence_bad_next = 1'b0;
        end
      end else begin
        // start of a new sequence
        sequence_bad_next       = 1'b0;
        continuations_left_next = lead.owed;
        if (lead.bad) begin
          text_failed_next = 1'b1;
        end
      end
      bytes_seen_next = bytes_seen + utf8s_pkg::CNT_W'(1);
    end
  end

  // verdict from the state that includes this item's byte
  always_comb begin
    if (text_failed_next) begin
      verdict.is_text = 1'b0;
    end else if (continuations_left_next != 2'd0) begin
      verdict.is_text = window_full;
    end else begin
      verdict.is_text = 1'b1;
    end
    verdict.is_program = (elf_prefix_match_next &&
                          bytes_seen_next >= utf8s_pkg::CNT_W'(4)) ||
                         (shebang_prefix_match_next &&
                          bytes_seen_next >= utf8s_pkg::CNT_W'(2));
  end

  // scan state, cleared on reset and after the last item of a file
  always_ff @(posedge clk) begin
    if (rst || (advance && item.end_of_file)) begin
      bytes_seen           <= '0;
      continuations_left   <= 2'd0;
      text_failed          <= 1'b0;
      sequence_bad         <= 1'b0;
      elf_prefix_match     <= 1'b1;
      shebang_prefix_match <= 1'b1;
    end else if (advance) begin
      bytes_seen           <= bytes_seen_next;
      continuations_left   <= continuations_left_next;
      text_failed          <= text_failed_next;
      sequence_bad         <= sequence_bad_next;
      elf_prefix_match     <= elf_prefix_match_next;
      shebang_prefix_match <= shebang_prefix_match_next;
    end
  end

endmodule

// ----- design/utf8s_out_reg.sv -----
// result register of the sniffer, holds a verdict until the sink takes it
module utf8s_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  utf8s_pkg::verdict_t verdict,
  input  logic                m_axis_tready,
  output logic                m_axis_tvalid,
  output logic [7:0]          m_axis_tdata
);

  utf8s_pkg::verdict_t held;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= verdict;
    end
  end

  assign m_axis_tdata = {6'd0, held.is_program, held.is_text};

endmodule

// ----- design/utf8_text_and_program_sniffer.sv -----
// top level of the utf-8 text and program sniffer
// Takes one file byte per item and gives one result item (is_text, is_program) on the
// item that carries tlast; only the first utf8s_pkg::WINDOW_BYTES bytes are examined.
// The block accepts one item every cycle unless a waiting result stalls it: the scan state
// (byte count, owed continuation bytes and match flags) updates combinationally from the
// input register and is registered as each item moves on. A result becomes valid once its
// last item has passed the input register and its verdict has loaded the result register.
// Items that carry no tlast keep flowing while an earlier result waits; only an item that
// carries tlast is held in the input register until the waiting result is taken, and the
// input stalls behind it.
module utf8_text_and_program_sniffer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] byte_present
  input  logic       s_axis_tlast,   // end_of_file
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] is_text, [1] is_program, [7:2] zero
);

  logic                in_valid;
  utf8s_pkg::item_t    in_item;
  logic                advance;
  utf8s_pkg::verdict_t verdict;

  // the held item moves on unless its verdict would overwrite a result not yet taken
  assign advance       = in_valid &&
                         (!in_item.end_of_file || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.data_byte    <= s_axis_tdata;
      in_item.byte_present <= s_axis_tuser;
      in_item.end_of_file  <= s_axis_tlast;
    end
  end

  utf8s_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .verdict (verdict)
  );

  utf8s_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance && in_item.end_of_file),
    .verdict       (verdict),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- design/utf8s_checker.sv -----
// port-level checks of the sniffer and their binding to the top level
module utf8s_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // reset leaves no result pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("state not cleared by reset");

  // with no result waiting the input never stalls
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // padding bits of a result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:2] == 6'd0)
    else $error("result padding not zero");

endmodule

bind utf8_text_and_program_sniffer utf8s_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
